// File: rtl/scheduled_sine_beep_generator_assert.svh
// Assertion macros for the scheduled sine beep generator.
// Used by modules that have i_clk and i_rst_n in scope; no other dependencies.
`ifndef SCHEDULED_SINE_BEEP_GENERATOR_ASSERT_SVH
`define SCHEDULED_SINE_BEEP_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define SSBG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
`define SSBG_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);
`else
`define SSBG_ASSERT(lbl, prop, msg)
`define SSBG_NEVER(lbl, cond, msg)
`endif

`endif

// File: rtl/ssbg_pkg.sv
// Shared types, constants and the sine table builder for the beep generator.
// No dependencies.
package ssbg_pkg;

    localparam int FREQ_W   = 15;
    localparam int TIME_W   = 32;
    localparam int DUR_W    = 16;
    localparam int IDX_W    = 17;   // holds any sample counter value up to 96000
    localparam int SMP_W    = 15;
    localparam int AMP_W    = 14;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [AMP_W-1:0] BEEP_AMP = 14'd10000;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        AMP_ZERO,
        AMP_ONE,
        AMP_BEEP
    } t_amp_sel;

    // One classified tick handed from the scheduler to the synthesizer.
    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [IDX_W-1:0]  index;
        t_amp_sel          amp;
        logic              active;
    } t_tone_cmd;

    // Q15 sine of k/2^qbits quarter turns, Q30 Taylor series up to x^13.
    function automatic logic [15:0] sine_q15(input int unsigned k, input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x    = (HALF_PI_Q30 * 64'(k)) >> qbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        r = (sum + (64'd1 << 14)) >> 15;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return r[15:0];
    endfunction

endpackage

// File: rtl/ssbg_front.sv
// Beat scheduler: latches requests, starts and ends beeps, steps the sample counter.
// Depends on ssbg_pkg.
module ssbg_front #(
    parameter int SAMPLE_RATE = 44100
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  logic [ssbg_pkg::TIME_W-1:0] i_now_ms,
    input  logic                      i_link_connected,
    input  logic                      i_beep_request,
    input  logic [ssbg_pkg::FREQ_W-1:0] i_beep_freq_hz,
    input  logic [ssbg_pkg::TIME_W-1:0] i_beep_start_ms,
    input  logic [ssbg_pkg::DUR_W-1:0]  i_beep_duration_ms,
    output ssbg_pkg::t_tone_cmd       o_cmd
);
    import ssbg_pkg::*;

    localparam logic [IDX_W:0] SR_X = (IDX_W+1)'(SAMPLE_RATE);

    logic              r_pending;
    logic              r_active;
    logic [FREQ_W-1:0] r_tone_freq;
    logic [TIME_W-1:0] r_pend_start;
    logic [DUR_W-1:0]  r_pend_dur;
    logic [TIME_W-1:0] r_end_time;
    logic [IDX_W-1:0]  r_index;

    logic [FREQ_W-1:0] w_freq;
    logic [TIME_W-1:0] w_start;
    logic [DUR_W-1:0]  w_dur;
    logic              w_pend;
    logic              w_go;
    logic              w_active;
    logic [TIME_W-1:0] w_end;
    logic [IDX_W-1:0]  w_index;
    logic              w_beep;
    logic [IDX_W:0]    w_inc;

    always_comb begin
        w_freq   = i_beep_request ? i_beep_freq_hz     : r_tone_freq;
        w_start  = i_beep_request ? i_beep_start_ms    : r_pend_start;
        w_dur    = i_beep_request ? i_beep_duration_ms : r_pend_dur;
        w_pend   = i_beep_request | r_pending;
        w_go     = w_pend & ~r_active & (i_now_ms >= w_start);
        w_active = r_active | w_go;
        w_end    = w_go ? (i_now_ms + TIME_W'(w_dur)) : r_end_time;
        w_index  = w_go ? '0 : r_index;
        w_beep   = w_active & (i_now_ms < w_end) & (w_freq != '0);
        w_inc    = {1'b0, w_index} + 1'b1;

        o_cmd.freq   = w_beep ? w_freq : FREQ_W'(1);
        o_cmd.index  = w_index;
        o_cmd.active = w_beep;
        if (w_beep) begin
            o_cmd.amp = AMP_BEEP;
        end else if (i_link_connected) begin
            o_cmd.amp = AMP_ONE;
        end else begin
            o_cmd.amp = AMP_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= 1'b0;
            r_active     <= 1'b0;
            r_tone_freq  <= '0;
            r_pend_start <= '0;
            r_pend_dur   <= '0;
            r_end_time   <= '0;
            r_index      <= '0;
        end else if (i_fire) begin
            r_pending    <= w_pend & ~w_go;
            r_active     <= w_beep;
            // a beep that just ended clears the frequency
            r_tone_freq  <= (w_active & ~w_beep) ? '0 : w_freq;
            r_pend_start <= w_start;
            r_pend_dur   <= w_dur;
            r_end_time   <= w_end;
            r_index      <= (w_inc >= SR_X) ? '0 : w_inc[IDX_W-1:0];
        end
    end

endmodule

// File: rtl/ssbg_fifo.sv
// Short command queue between scheduler and synthesizer.
// Depends on ssbg_pkg.
module ssbg_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ssbg_pkg::t_tone_cmd i_cmd,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output ssbg_pkg::t_tone_cmd o_cmd
);
    import ssbg_pkg::*;

    t_tone_cmd          r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic               w_do_push;
    logic               w_do_pop;

    assign o_full    = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_cmd     = r_mem[r_rd_ptr];
    assign w_do_push = i_push & ~o_full;
    assign w_do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/ssbg_synth.sv
// Sine synthesis pipeline: phase modulo, table index, quarter-wave lookup, scaling.
// Depends on ssbg_pkg and scheduled_sine_beep_generator_assert.svh.
`include "scheduled_sine_beep_generator_assert.svh"
module ssbg_synth #(
    parameter int SAMPLE_RATE     = 44100,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  ssbg_pkg::t_tone_cmd           i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [ssbg_pkg::SMP_W-1:0] o_sample,
    output logic                          o_active
);
    import ssbg_pkg::*;

    localparam int TB      = SINE_TABLE_BITS;
    localparam int SR_W    = $clog2(SAMPLE_RATE + 1);
    localparam int PW      = FREQ_W + SR_W;
    localparam int RECIP   = int'((64'd1 << 32) / 64'(SAMPLE_RATE));
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int M1W     = PW + RECIP_W;
    localparam int Q1W     = M1W - 32;
    localparam int TW      = SR_W + TB;
    localparam int M2W     = TW + RECIP_W;
    localparam int QLEN    = 1 << (TB - 2);
    localparam int AW      = TB - 1;
    localparam int NSTG    = 8;

    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam logic [SR_W:0]      SR_R    = (SR_W+1)'(SAMPLE_RATE);
    localparam logic [SR_W+1:0]    SR2     = (SR_W+2)'(2 * SAMPLE_RATE);

    logic             w_en;
    logic             r_v   [1:NSTG];
    t_amp_sel         r_amp [1:NSTG];
    logic             r_act [1:NSTG];

    logic [PW-1:0]    r_prod;
    logic [PW-1:0]    r_prod2;
    logic [Q1W-1:0]   r_q1;
    logic [SR_W:0]    r_rem1;
    logic [TW-1:0]    r_t;
    logic [TW-1:0]    r_t5;
    logic [TB-1:0]    r_q2;
    logic [TB-1:0]    r_q2_6;
    logic [SR_W:0]    r_rem2;
    logic [15:0]      r_s;
    logic             r_neg7;
    logic [SMP_W-1:0] r_mag;
    logic             r_neg8;
    logic [SMP_W-1:0] r_out_sample;
    logic             r_out_active;
    logic             r_out_valid;

    logic [M1W-1:0]   w_m1;
    logic [PW-1:0]    w_qs1;
    logic [SR_W-1:0]  w_phase;
    logic [M2W-1:0]   w_m2;
    logic [TW-1:0]    w_qs2;
    logic [TB-1:0]    w_idx;
    logic [AW-1:0]    w_off;
    logic [AW-1:0]    w_addr;
    logic [AMP_W-1:0] w_ampv;
    logic [AMP_W+15:0] w_scaled;
    logic [15:0]      w_rom [QLEN+1];

    // quarter-wave table, folded to constants
    always_comb begin
        for (int k = 0; k <= QLEN; k++) begin
            w_rom[k] = sine_q15(k, TB - 2);
        end
    end

    // whole pipeline advances unless the output register is held
    assign w_en      = ~r_out_valid | i_ready;
    assign o_cmd_pop = w_en;

    always_comb begin
        w_m1    = M1W'(r_prod) * M1W'(RECIP_C);
        w_qs1   = PW'(PW'(r_q1) * PW'(SAMPLE_RATE));
        w_phase = (r_rem1 >= SR_R) ? SR_W'(r_rem1 - SR_R) : r_rem1[SR_W-1:0];
        w_m2    = M2W'(r_t) * M2W'(RECIP_C);
        w_qs2   = TW'(TW'(r_q2) * TW'(SAMPLE_RATE));
        w_idx   = r_q2_6 + TB'(r_rem2 >= SR_R);
        w_off   = AW'(w_idx[TB-3:0]);
        w_addr  = w_idx[TB-2] ? AW'(QLEN - int'(w_off)) : w_off;
        case (r_amp[7])
            AMP_ONE:  w_ampv = AMP_W'(1);
            AMP_BEEP: w_ampv = BEEP_AMP;
            default:  w_ampv = '0;
        endcase
        w_scaled = (AMP_W+16)'(w_ampv) * (AMP_W+16)'(r_s);
    end

    // tag and valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NSTG; k++) begin
                r_v[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v[1] <= i_cmd_valid;
            for (int k = 2; k <= NSTG; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_out_valid <= r_v[NSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_amp[1] <= i_cmd.amp;
            r_act[1] <= i_cmd.active;
            for (int k = 2; k <= NSTG; k++) begin
                r_amp[k] <= r_amp[k-1];
                r_act[k] <= r_act[k-1];
            end
            r_prod       <= PW'(PW'(i_cmd.freq) * PW'(i_cmd.index[SR_W-1:0]));
            r_prod2      <= r_prod;
            r_q1         <= w_m1[M1W-1:32];
            r_rem1       <= (SR_W+1)'(r_prod2 - w_qs1);
            r_t          <= {w_phase, {TB{1'b0}}};
            r_t5         <= r_t;
            r_q2         <= w_m2[32 +: TB];
            r_q2_6       <= r_q2;
            r_rem2       <= (SR_W+1)'(r_t5 - w_qs2);
            r_s          <= w_rom[w_addr];
            r_neg7       <= w_idx[TB-1];
            r_mag        <= SMP_W'(w_scaled >> 15);
            r_neg8       <= r_neg7;
            r_out_sample <= r_neg8 ? SMP_W'(-r_mag) : r_mag;
            r_out_active <= r_act[NSTG];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_sample = signed'(r_out_sample);
    assign o_active = r_out_active;

    `SSBG_ASSERT(a_phase_reduced, r_v[4] |-> (r_t[TW-1:TB] < SR_R[SR_W-1:0]), "phase not below rate")
    `SSBG_ASSERT(a_rem_bound, r_v[6] |-> ({1'b0, r_rem2} < SR2), "index remainder out of bound")
    `SSBG_ASSERT(a_silent_zero, (r_v[8] && (r_amp[8] == AMP_ZERO)) |-> (r_mag == '0), "muted tick not silent")

endmodule

// File: rtl/scheduled_sine_beep_generator.sv
// Top level of the scheduled sine beep generator: stream ports, scheduler, queue, synthesizer.
// Depends on ssbg_pkg, ssbg_front, ssbg_fifo and ssbg_synth.
//
// Usage:
//  - Every input beat on s_axis is one audio sample tick. tdata carries the current time
//    in ms and the link flag; when tuser is high the beat also carries a beep request
//    (frequency, start time, duration) that replaces any pending one.
//  - Every input beat yields exactly one output beat on m_axis: two equal signed samples
//    and, in tuser, whether a beep sounds on that tick.
//  - Throughput: one beat per clock when the receiver keeps m_axis_tready high.
//  - Path: an accepted beat reaches m_axis through the queue and the synthesizer
//    pipeline: phase product, two constant reciprocal modulo steps, the quarter-wave
//    table read and the amplitude multiply, then the output register.
//  - Receiver stall: the synthesizer pipeline freezes with the output register held;
//    the scheduler keeps accepting into a four-entry queue and drops s_axis_tready
//    only once that queue is full.
//  - Reset (i_rst_n low, synchronous): no pending or active beep, frequency zero, sample
//    counter zero, queue and pipeline empty. The sine table is constant logic, so the
//    block accepts beats in the first cycle after reset.
module scheduled_sine_beep_generator #(
    parameter int SAMPLE_RATE     = 44100,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] now_ms, [32] link_connected, [47:33] beep_freq_hz,
    // [79:48] beep_start_ms, [95:80] beep_duration_ms
    input  logic [95:0] s_axis_tdata,
    // [0] beep_request
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [14:0] left_sample, [29:15] right_sample, [31:30] zero
    output logic [31:0] m_axis_tdata,
    // [0] tone_active
    output logic        m_axis_tuser
);
    import ssbg_pkg::*;

    logic                     w_full;
    logic                     w_fire;
    t_tone_cmd                w_front_cmd;
    logic                     w_q_valid;
    t_tone_cmd                w_q_cmd;
    logic                     w_q_pop;
    logic signed [SMP_W-1:0]  w_sample;
    logic                     w_active;

    assign s_axis_tready = ~w_full;
    assign w_fire        = s_axis_tvalid & ~w_full;

    // scheduler: all beep state lives here and advances once per accepted beat
    ssbg_front #(
        .SAMPLE_RATE(SAMPLE_RATE)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (w_fire),
        .i_now_ms          (s_axis_tdata[31:0]),
        .i_link_connected  (s_axis_tdata[32]),
        .i_beep_request    (s_axis_tuser),
        .i_beep_freq_hz    (s_axis_tdata[47:33]),
        .i_beep_start_ms   (s_axis_tdata[79:48]),
        .i_beep_duration_ms(s_axis_tdata[95:80]),
        .o_cmd             (w_front_cmd)
    );

    // decoupling queue so scheduler and synthesizer stall independently
    ssbg_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_fire),
        .i_cmd  (w_front_cmd),
        .o_full (w_full),
        .i_pop  (w_q_pop),
        .o_valid(w_q_valid),
        .o_cmd  (w_q_cmd)
    );

    // synthesizer pipeline with its own output register
    ssbg_synth #(
        .SAMPLE_RATE    (SAMPLE_RATE),
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_synth (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(w_q_valid),
        .i_cmd      (w_q_cmd),
        .o_cmd_pop  (w_q_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_sample   (w_sample),
        .o_active   (w_active)
    );

    // both channels carry the same sample
    assign m_axis_tdata = {2'b00, w_sample, w_sample};
    assign m_axis_tuser = w_active;

endmodule

// File: tb/tb_scheduled_sine_beep_generator.sv
// Self-checking testbench for scheduled_sine_beep_generator: drives sample ticks on s_axis,
// predicts every output beat with its own tone scheduler and quarter-wave sine table.
// Depends on ssbg_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_scheduled_sine_beep_generator;

    import ssbg_pkg::*;

    localparam int SAMPLE_RATE  = 44100;
    localparam int TABLE_BITS   = 10;
    localparam int QUARTER      = 1 << (TABLE_BITS - 2);
    localparam int LIMIT_CYCLES = 100_000;
    localparam int DRAIN_CYCLES = 24;   // drain time for the pipeline, with margin

    // One output beat as the scheduler predicts it.
    typedef struct {
        logic [SMP_W-1:0] left;
        logic [SMP_W-1:0] right;
        logic             active;
    } t_tick_out;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [31:0] now_ms, [32] link_connected, [47:33] beep_freq_hz,
    // [79:48] beep_start_ms, [95:80] beep_duration_ms
    logic [95:0] s_axis_tdata  = '0;
    // [0] beep_request
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [14:0] left_sample, [29:15] right_sample, [31:30] zero
    logic [31:0] m_axis_tdata;
    // [0] tone_active
    logic        m_axis_tuser;

    scheduled_sine_beep_generator #(
        .SAMPLE_RATE     (SAMPLE_RATE),
        .SINE_TABLE_BITS (TABLE_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Tone scheduler mirror
    // ------------------------------------------------------------------
    logic [15:0]        sine_quarter [0:QUARTER];
    logic               beep_armed  = 1'b0;
    logic               beep_on     = 1'b0;
    logic [FREQ_W-1:0]  cur_freq    = '0;
    logic [TIME_W-1:0]  armed_start = '0;
    logic [DUR_W-1:0]   armed_len   = '0;
    logic [TIME_W-1:0]  beep_end    = '0;
    int unsigned        tick_index  = 0;

    t_tick_out sample_queue [$];
    int        errors = 0;

    // Quarter-wave table in Q15: Q30 Taylor series through x^13, rounded half up.
    initial begin : build_sine_quarter
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] term;
        bit [63:0] sum;
        bit [63:0] r;
        for (int k = 0; k <= QUARTER; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) / 64'(QUARTER);
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int i = 1; i <= 6; i++) begin
                term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
                if (i % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            r = (sum + (64'd1 << 14)) >> 15;
            if (r > 64'd32768) begin
                r = 64'd32768;
            end
            sine_quarter[k] = r[15:0];
        end
    end

    // amp * sin(2*pi*f*n/SAMPLE_RATE), truncated toward zero, as a 15-bit two's complement.
    function automatic logic [SMP_W-1:0] tone_value(input int unsigned f,
                                                    input int unsigned n,
                                                    input int unsigned amp);
        bit [63:0]        phase;
        int unsigned      idx;
        int unsigned      quad;
        int unsigned      off;
        int unsigned      s;
        int unsigned      mag;
        logic [SMP_W-1:0] m15;
        phase = (64'(f) * 64'(n)) % 64'(SAMPLE_RATE);
        idx   = int'((phase << TABLE_BITS) / 64'(SAMPLE_RATE));
        quad  = (idx >> (TABLE_BITS - 2)) & 3;
        off   = idx & (QUARTER - 1);
        s     = (quad & 1) ? sine_quarter[QUARTER - off] : sine_quarter[off];
        mag   = (amp * s) >> 15;
        m15   = mag[SMP_W-1:0];
        return (quad & 2) ? -m15 : m15;
    endfunction

    // Advance the scheduler by one sample tick and return the beat it yields.
    function automatic t_tick_out synth_tick(input logic [TIME_W-1:0] now,
                                             input logic              link,
                                             input logic              req,
                                             input logic [FREQ_W-1:0] freq,
                                             input logic [TIME_W-1:0] start,
                                             input logic [DUR_W-1:0]  dur);
        t_tick_out   o;
        int unsigned f;
        int unsigned amp;
        // request lands first, then the start check sees it in the same tick
        if (req) begin
            cur_freq    = freq;
            armed_start = start;
            armed_len   = dur;
            beep_armed  = 1'b1;
        end
        if (beep_armed && !beep_on && now >= armed_start) begin
            tick_index = 0;
            beep_on    = 1'b1;
            beep_armed = 1'b0;
            beep_end   = now + TIME_W'(armed_len);   // wraps modulo 2^32
        end
        f   = 1;
        amp = link ? 1 : 0;
        if (beep_on) begin
            if (now < beep_end && cur_freq != '0) begin
                f   = cur_freq;
                amp = BEEP_AMP;
            end else begin
                beep_on  = 1'b0;
                cur_freq = '0;
            end
        end
        o.left     = tone_value(f, tick_index, amp);
        o.right    = o.left;
        o.active   = beep_on;
        tick_index = (tick_index + 1 >= SAMPLE_RATE) ? 0 : tick_index + 1;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps, occasional calm stretches
    // ------------------------------------------------------------------
    int burst_left = 0;
    bit calm       = 1'b0;

    task automatic send_tick(input logic [TIME_W-1:0] now,
                             input logic              link,
                             input logic              req,
                             input logic [FREQ_W-1:0] freq,
                             input logic [TIME_W-1:0] start,
                             input logic [DUR_W-1:0]  dur);
        int        gap;
        t_tick_out beat;
        if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
                calm = ~calm;
            end
            gap        = calm ? 0 : $urandom_range(0, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dur, start, freq, link, now};
        s_axis_tuser  <= req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        beat         = synth_tick(now, link, req, freq, start, dur);
        sample_queue = {sample_queue, beat};
    endtask

    // Tick without a request; the request fields carry noise that must be ignored.
    task automatic plain_tick(input logic [TIME_W-1:0] now, input logic link);
        send_tick(now, link, 1'b0, FREQ_W'($urandom), $urandom, DUR_W'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready runs, short stalls, now and then a long stall-free stretch
    // ------------------------------------------------------------------
    int rx_left = 0;

    always @(posedge i_clk) begin : rx_pattern
        int pick;
        if (rx_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                m_axis_tready <= 1'b1;
                rx_left = $urandom_range(1, 12);
            end else if (pick < 9) begin
                m_axis_tready <= 1'b0;
                rx_left = $urandom_range(1, 5);
            end else begin
                m_axis_tready <= 1'b1;
                rx_left = $urandom_range(64, 200);
            end
        end else begin
            rx_left--;
        end
    end

    // ------------------------------------------------------------------
    // Output beat check against the oldest predicted beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_samples
        t_tick_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (sample_queue.size() == 0) begin
                $error("output beat with no tick outstanding: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                want = sample_queue.pop_front();
                if (m_axis_tdata[14:0] !== want.left) begin
                    $error("left_sample: expected %0d, got %0d",
                           $signed(want.left), $signed(m_axis_tdata[14:0]));
                    errors++;
                end
                if (m_axis_tdata[29:15] !== want.right) begin
                    $error("right_sample: expected %0d, got %0d",
                           $signed(want.right), $signed(m_axis_tdata[29:15]));
                    errors++;
                end
                if (m_axis_tuser !== want.active) begin
                    $error("tone_active: expected %0d, got %0d", want.active, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    int cycles = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // No beep: link off gives silence, link on gives the unit-amplitude 1 Hz tone.
    task automatic test_idle_link();
        plain_tick(32'd0, 1'b0);
        plain_tick(32'd1, 1'b0);
        plain_tick(32'd2, 1'b1);
        plain_tick(32'd3, 1'b1);
    endtask

    // Request with start == now sounds on the same tick; a future start waits for its time.
    task automatic test_request_order();
        send_tick(32'd10, 1'b1, 1'b1, 15'd440, 32'd10, 16'd3);
        plain_tick(32'd11, 1'b1);
        plain_tick(32'd12, 1'b1);
        plain_tick(32'd13, 1'b1);                 // reaches end time, drops
        send_tick(32'd14, 1'b0, 1'b1, 15'd1000, 32'd20, 16'd2);
        plain_tick(32'd18, 1'b0);
        plain_tick(32'd20, 1'b0);
        plain_tick(32'd21, 1'b0);
        plain_tick(32'd22, 1'b0);
    endtask

    // New request during a beep: frequency switches at once, start waits for the end.
    task automatic test_request_while_active();
        send_tick(32'd30, 1'b1, 1'b1, 15'd300, 32'd30, 16'd10);
        send_tick(32'd31, 1'b1, 1'b1, 15'd5000, 32'd33, 16'd4);
        plain_tick(32'd35, 1'b1);
        plain_tick(32'd40, 1'b1);                 // old beep ends, armed start not taken yet
        plain_tick(32'd41, 1'b1);                 // armed start taken, freq cleared: silent
    endtask

    // Zero frequency: a beep started with it drops in its own tick.
    task automatic test_cancel();
        send_tick(32'd42, 1'b1, 1'b1, 15'd0, 32'd0, 16'd50);
        plain_tick(32'd43, 1'b1);
    endtask

    // Largest 15-bit frequency and longest duration, then a zero-length beep.
    task automatic test_extremes();
        send_tick(32'd50, 1'b1, 1'b1, 15'h7FFF, 32'd50, 16'hFFFF);
        send_tick(32'd51, 1'b1, 1'b1, 15'd20000, 32'd0, 16'd0);
        plain_tick(32'd65585, 1'b1);
        plain_tick(32'd65586, 1'b1);
    endtask

    // End time wrapping past 2^32 compares below now and drops at once.
    task automatic test_time_wrap();
        send_tick(32'hFFFF_FFF0, 1'b1, 1'b1, 15'd1500, 32'hFFFF_FFF0, 16'd100);
        send_tick(32'hFFFF_FFFD, 1'b0, 1'b1, 15'd2500, 32'hFFFF_FFFE, 16'd1);
        plain_tick(32'hFFFF_FFFE, 1'b0);
        plain_tick(32'hFFFF_FFFF, 1'b0);
    endtask

    // A held beep steps the sample counter tick by tick on one frequency,
    // then ends exactly at its end time and falls back to the idle tone.
    task automatic test_held_beep();
        send_tick(32'd1000, 1'b1, 1'b1, 15'd997, 32'd1000, 16'hFFFF);
        repeat (16) plain_tick(32'd1000, 1'b1);
        plain_tick(32'd66535, 1'b1);
        plain_tick(32'd66536, 1'b1);
    endtask

    // Mostly well-formed schedules on a slowly advancing clock, with time jumps,
    // far-off starts, long durations and out-of-range frequencies mixed in.
    task automatic test_random_schedule(input int n_items);
        logic [TIME_W-1:0] ms;
        logic              link;
        int                pick;
        logic [FREQ_W-1:0] f;
        logic [TIME_W-1:0] st;
        logic [DUR_W-1:0]  d;
        ms   = $urandom_range(0, 1000);
        link = 1'b1;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                ms = $urandom;
            end else if (pick < 5) begin
                ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
            end else begin
                ms = ms + $urandom_range(0, 2);
            end
            if ($urandom_range(0, 29) == 0) begin
                link = ~link;
            end
            if ($urandom_range(0, 14) == 0) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    f = '0;
                end else if (pick == 1) begin
                    f = FREQ_W'($urandom);
                end else begin
                    f = FREQ_W'($urandom_range(1, 20000));
                end
                st = ($urandom_range(0, 9) == 0) ? $urandom : ms + $urandom_range(0, 30);
                d  = ($urandom_range(0, 9) == 0) ? DUR_W'($urandom)
                                                  : DUR_W'($urandom_range(0, 60));
                send_tick(ms, link, 1'b1, f, st, d);
            end else begin
                plain_tick(ms, link);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_link();
        test_request_order();
        test_request_while_active();
        test_cancel();
        test_extremes();
        test_time_wrap();
        test_held_beep();
        test_random_schedule(600);

        s_axis_tvalid <= 1'b0;
        while (sample_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: scheduled_sine_beep_generator.f
+incdir+rtl
rtl/ssbg_pkg.sv
rtl/ssbg_front.sv
rtl/ssbg_fifo.sv
rtl/ssbg_synth.sv
rtl/scheduled_sine_beep_generator.sv
tb/tb_scheduled_sine_beep_generator.sv
